>>> hw/rtl/ipv4dq_pkg.sv
// shared constants and types for the ipv4 dotted-quad parser
package ipv4dq_pkg;

  localparam int MAX_LEN    = 15;
  localparam int LEN_W      = $clog2(MAX_LEN + 2);
  localparam int TOK_W      = 3;
  localparam int VAL_W      = 9;
  localparam int STATUS_W   = 3;
  localparam int OCTET_W    = 8;
  localparam int NUM_OCTETS = 4;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_BITS   = STATUS_W + NUM_OCTETS * OCTET_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [7:0]       DOT_CHAR   = 8'h2E;
  localparam logic [VAL_W-1:0] OCTET_MAX  = VAL_W'(255);
  localparam logic [VAL_W-1:0] VALUE_SAT  = VAL_W'(256);
  localparam logic [TOK_W-1:0] TOKENS_SAT = TOK_W'(5);
  localparam logic [TOK_W-1:0] TOKENS_OK  = TOK_W'(4);

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID    = 3'd0,
    ST_LENGTH   = 3'd1,
    ST_NONDIGIT = 3'd2,
    ST_RANGE    = 3'd3,
    ST_COUNT    = 3'd4
  } status_t;

  typedef logic [OCTET_W-1:0] octet_t;

endpackage

>>> hw/rtl/ipv4_dotted_quad_parser.sv
// ipv4 dotted-quad text parser: one character per transfer, one verdict per string
// the verdict is registered on the terminator transfer and is on the output in the cycle after it
// throughput: one character or terminator per cycle while the output is not stalled
// the single output register is the only limit; it is refilled in the cycle it is taken
// reset clears the control state and empties the output register; the datapath registers are not reset
module ipv4_dotted_quad_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ipv4dq_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // character
  input  logic                                s_axis_tlast,  // end_of_string
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status, octet_first, octet_second, octet_third, octet_fourth, zero fill
  output logic [ipv4dq_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  logic [ipv4dq_pkg::LEN_W-1:0] length_seen;
  logic [ipv4dq_pkg::TOK_W-1:0] tokens_done;
  logic                         inside_token;
  logic [ipv4dq_pkg::VAL_W-1:0] token_value;
  logic                         token_has_nondigit;
  ipv4dq_pkg::status_t          first_error;
  ipv4dq_pkg::octet_t           octet_store [ipv4dq_pkg::NUM_OCTETS];

  ipv4dq_pkg::status_t          out_status;
  ipv4dq_pkg::octet_t           out_octets [ipv4dq_pkg::NUM_OCTETS];

  logic                         in_xfer;
  logic                         is_dot;
  logic                         is_digit;
  logic                         checked;
  ipv4dq_pkg::status_t          close_error;
  logic                         close_store;
  ipv4dq_pkg::status_t          error_after;
  logic [1:0]                   slot;
  logic [ipv4dq_pkg::VAL_W-1:0] base_value;
  logic [12:0]                  digit_sum;
  logic [ipv4dq_pkg::VAL_W-1:0] value_next;
  ipv4dq_pkg::status_t          status_next;
  ipv4dq_pkg::octet_t           octets_next [ipv4dq_pkg::NUM_OCTETS];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    is_dot   = (s_axis_tdata == ipv4dq_pkg::DOT_CHAR);
    is_digit = s_axis_tdata inside {[8'h30:8'h39]};

    // closing check for the token in progress, only for the first four
    checked = inside_token && (tokens_done != '0) && (tokens_done <= ipv4dq_pkg::TOKENS_OK)
              && (first_error == ipv4dq_pkg::ST_VALID);
    if (token_has_nondigit) begin
      close_error = ipv4dq_pkg::ST_NONDIGIT;
    end else if (token_value > ipv4dq_pkg::OCTET_MAX) begin
      close_error = ipv4dq_pkg::ST_RANGE;
    end else begin
      close_error = ipv4dq_pkg::ST_VALID;
    end
    close_store = checked && (close_error == ipv4dq_pkg::ST_VALID);
    error_after = checked ? close_error : first_error;
    slot        = tokens_done[1:0] - 2'd1;

    // decimal accumulate, saturating
    base_value = inside_token ? token_value : '0;
    digit_sum  = {1'b0, base_value, 3'b000} + {3'b000, base_value, 1'b0}
                 + {9'd0, s_axis_tdata[3:0]};
    value_next = (digit_sum > 13'(ipv4dq_pkg::VALUE_SAT)) ? ipv4dq_pkg::VALUE_SAT
                                                          : digit_sum[ipv4dq_pkg::VAL_W-1:0];

    if ((length_seen == '0) || (length_seen > ipv4dq_pkg::LEN_W'(ipv4dq_pkg::MAX_LEN))) begin
      status_next = ipv4dq_pkg::ST_LENGTH;
    end else if (error_after != ipv4dq_pkg::ST_VALID) begin
      status_next = error_after;
    end else if (tokens_done != ipv4dq_pkg::TOKENS_OK) begin
      status_next = ipv4dq_pkg::ST_COUNT;
    end else begin
      status_next = ipv4dq_pkg::ST_VALID;
    end

    for (int i = 0; i < ipv4dq_pkg::NUM_OCTETS; i++) begin
      if (status_next != ipv4dq_pkg::ST_VALID) begin
        octets_next[i] = '0;
      end else if (close_store && (slot == 2'(i))) begin
        octets_next[i] = token_value[ipv4dq_pkg::OCTET_W-1:0];
      end else begin
        octets_next[i] = octet_store[i];
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      length_seen   <= '0;
      tokens_done   <= '0;
      inside_token  <= 1'b0;
      first_error   <= ipv4dq_pkg::ST_VALID;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_xfer && s_axis_tlast) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (in_xfer) begin
        if (s_axis_tlast) begin
          length_seen   <= '0;
          tokens_done   <= '0;
          inside_token  <= 1'b0;
          first_error   <= ipv4dq_pkg::ST_VALID;
        end else begin
          if (length_seen <= ipv4dq_pkg::LEN_W'(ipv4dq_pkg::MAX_LEN)) begin
            length_seen <= length_seen + 1'b1;
          end
          if (is_dot) begin
            inside_token <= 1'b0;
            first_error  <= error_after;
          end else if (!inside_token) begin
            inside_token <= 1'b1;
            if (tokens_done < ipv4dq_pkg::TOKENS_SAT) begin
              tokens_done <= tokens_done + 1'b1;
            end
          end
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (s_axis_tlast) begin
        out_status <= status_next;
        out_octets <= octets_next;
      end else if (is_dot) begin
        if (close_store) begin
          octet_store[slot] <= token_value[ipv4dq_pkg::OCTET_W-1:0];
        end
      end else begin
        token_has_nondigit <= (inside_token && token_has_nondigit) || !is_digit;
        if (is_digit) begin
          token_value <= value_next;
        end else begin
          token_value <= base_value;
        end
      end
    end
  end

  assign m_axis_tdata = {(ipv4dq_pkg::OUT_DATA_W - ipv4dq_pkg::OUT_BITS)'(0),
                         out_octets[3], out_octets[2], out_octets[1], out_octets[0],
                         out_status};

  a_octets_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_status != ipv4dq_pkg::ST_VALID)) |->
      ((out_octets[0] == '0) && (out_octets[1] == '0) &&
       (out_octets[2] == '0) && (out_octets[3] == '0)))
    else $error("octets not cleared on error verdict");

  a_no_result_on_char: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !s_axis_tlast) |=> !m_axis_tvalid)
    else $error("result produced by a character transfer");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_axis_tlast) |=>
      (m_axis_tvalid && !inside_token && (tokens_done == '0) && (length_seen == '0)
       && (first_error == ipv4dq_pkg::ST_VALID)))
    else $error("parser state not cleared after terminator");

  a_tokens_saturate: assert property (@(posedge clk) disable iff (rst)
    (tokens_done <= ipv4dq_pkg::TOKENS_SAT))
    else $error("token count beyond saturation");

endmodule
